// ===== hw/rtl/iea_pkg.sv =====
// shared types and constants of the indexed extent allocator
package iea_pkg;

  localparam int NUM_REGIONS = 16;
  localparam int ADDR_WIDTH  = 16;
  localparam int IDX_W       = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int CNT_W       = $clog2(NUM_REGIONS + 1);
  localparam int RCOUNT_W    = 5;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_ALLOC    = 1'b1;
  localparam logic KIND_INDEX  = 1'b0;
  localparam logic KIND_EXTENT = 1'b1;

  typedef logic [ADDR_WIDTH-1:0] addr_t;

  typedef struct packed {
    logic        operation;
    logic [3:0]  region_slot;
    logic [15:0] region_start;
    logic [15:0] region_size;
    logic [15:0] request_size;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        index_found;
    logic [3:0]  slot_number;
    logic [15:0] extent_start;
    logic [15:0] extent_size;
    logic [15:0] unmet_size;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/indexed_extent_allocator.sv =====
// indexed extent allocator top level: region table memory, scan sequencer and result staging
//
// A load transfer writes one region entry (start, size). An allocate
// transfer walks entries 0 to min(region_count, NUM_REGIONS)-1 through the region
// memory over its single synchronous read port, one entry per cycle while the result
// side does not stall: the first nonempty region is reported and emptied as the index
// block, later nonempty regions hand out first-fit extents and shrink from their front,
// and the walk stops once the request is met. An allocate holds off the input until
// the walk ends and its final result moves to the output register, and longer while
// the result side stalls.
// Results go out as an index report followed by one result per extent, the final one
// flagged last; without any nonempty region a single report with index_found low and
// last high is sent. One result is held back until the next one (or the end of the walk)
// decides its last flag, and a separate output register lets the next input transfer be
// taken while the final result still waits. Entries never loaded read back undefined.
// The configuration port takes region_count and should only be written while idle.
module indexed_extent_allocator
  import iea_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RCOUNT_W-1:0] cfg_data
);

  // region memory, one word per entry
  addr_t       start_mem [NUM_REGIONS];
  logic [15:0] size_mem  [NUM_REGIONS];
  addr_t       rd_start_r;
  logic [15:0] rd_size_r;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic                 have_idx_r, have_idx_nxt;
  logic                 hold_v_r, hold_v_nxt;
  out_item_t            hold_r, hold_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;
  logic [RCOUNT_W-1:0]  region_count_r;

  logic                 in_take;
  logic                 out_free;
  logic                 at_end;
  logic                 emit_req;
  logic                 can_emit;
  logic                 step;
  logic [15:0]          take;
  logic [15:0]          rem_after;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  addr_t                wr_start;
  logic [15:0]          wr_size;
  logic [IDX_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     idx_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign idx_inc   = idx_r + CNT_W'(1);

  // scan decisions for the entry whose read data is on hand
  always_comb begin
    at_end    = (idx_r >= count_r);
    emit_req  = (state_r == ST_SCAN) && !at_end && (rd_size_r != 16'd0);
    can_emit  = !hold_v_r || out_free;
    // advance past the current entry: skip an empty one, or once its result is staged
    step      = (state_r == ST_SCAN) && !at_end && (!emit_req || can_emit);
    take      = (rem_r < rd_size_r) ? rem_r : rd_size_r;
    rem_after = rem_r - take;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && in_data.operation == OP_ALLOC) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_end) begin
          state_nxt = ST_FIN;
        end else if (emit_req && can_emit) begin
          if (!have_idx_r) begin
            if (rem_r == 16'd0) state_nxt = ST_FIN;
          end else if (rem_after == 16'd0) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory port and result staging
  always_comb begin
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    have_idx_nxt  = have_idx_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_start      = rd_start_r;
    wr_size       = rd_size_r;
    rd_addr       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_data.operation == OP_LOAD) begin
            wr_en    = (int'(in_data.region_slot) < NUM_REGIONS);
            wr_addr  = IDX_W'(in_data.region_slot);
            wr_start = ADDR_WIDTH'(in_data.region_start);
            wr_size  = in_data.region_size;
          end else begin
            idx_nxt      = '0;
            count_nxt    = (int'(region_count_r) < NUM_REGIONS) ?
                           CNT_W'(region_count_r) : CNT_W'(NUM_REGIONS);
            rem_nxt      = in_data.request_size;
            have_idx_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // re-read the same entry while stalled, else fetch the following one
        rd_addr = step ? idx_inc[IDX_W-1:0] : idx_r[IDX_W-1:0];
        if (step) idx_nxt = idx_inc;
        if (at_end && !have_idx_r) begin
          hold_v_nxt             = 1'b1;
          hold_nxt.kind          = KIND_INDEX;
          hold_nxt.index_found   = 1'b0;
          hold_nxt.slot_number   = '0;
          hold_nxt.extent_start  = '0;
          hold_nxt.extent_size   = '0;
          hold_nxt.unmet_size    = rem_r;
          hold_nxt.last          = 1'b0;
        end
        if (emit_req && can_emit) begin
          if (hold_v_r) begin
            out_nxt       = hold_r;
            out_valid_nxt = 1'b1;
          end
          hold_v_nxt            = 1'b1;
          hold_nxt.index_found  = 1'b1;
          hold_nxt.slot_number  = 4'(idx_r);
          hold_nxt.extent_start = 16'(rd_start_r);
          hold_nxt.last         = 1'b0;
          wr_en                 = 1'b1;
          if (!have_idx_r) begin
            hold_nxt.kind        = KIND_INDEX;
            hold_nxt.extent_size = rd_size_r;
            hold_nxt.unmet_size  = rem_r;
            have_idx_nxt         = 1'b1;
            wr_size              = 16'd0;
          end else begin
            hold_nxt.kind        = KIND_EXTENT;
            hold_nxt.extent_size = take;
            hold_nxt.unmet_size  = rem_after;
            rem_nxt              = rem_after;
            wr_start             = rd_start_r + ADDR_WIDTH'(take);
            wr_size              = rd_size_r - take;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_nxt       = hold_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          hold_v_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_addr] <= wr_start;
      size_mem[wr_addr]  <= wr_size;
    end
    rd_start_r <= start_mem[rd_addr];
    rd_size_r  <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      hold_v_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      have_idx_r     <= 1'b0;
      region_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      have_idx_r  <= have_idx_nxt;
      if (cfg_valid && cfg_ready) region_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    count_r <= count_nxt;
    rem_r   <= rem_nxt;
    hold_r  <= hold_nxt;
    out_r   <= out_nxt;
  end

  // input is only taken once the held result has gone out
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !hold_v_r)
    else $error("input taken while a result is still held");

  // the walk never runs past the latched entry count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= count_r))
    else $error("scan index beyond entry count");

  // a held result during the walk always follows an index block
  a_hold_has_index: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && state_r == ST_SCAN) |-> have_idx_r)
    else $error("result held without an index block");

  // a no-index report only exists on the way out
  a_noindex_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_v_r && !hold_r.index_found) |-> (state_r == ST_FIN))
    else $error("no-index report outside the final state");

  // the unmet size only shrinks during a walk
  a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (rem_r <= $past(rem_r)))
    else $error("unmet size grew during a scan");

endmodule
